// ===== sv/sidt_pkg.sv =====
// Shared types for the sorted ID table: command codes, result status codes
// and the command bundle from the controller to the datapath.
// No dependencies.
package sidt_pkg;

	// Command codes carried on the opcode port.
	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_LOOKUP = 2'd2
	} op_t;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;  // take a new item and register the cell compares
		logic apply;    // shift the cells, update the count, form the result
	} sidt_cmd_t;

endpackage

// ===== sv/sidt_ctrl.sv =====
// Controller for the sorted ID table: a two-state sequencer that accepts
// an item, runs the apply step and raises the result strobe.
// Depends on sidt_pkg.
module sidt_ctrl
	import sidt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	output logic      done,
	output sidt_cmd_t cmd
);

	typedef enum logic {
		S_IDLE,
		S_APPLY
	} state_t;

	state_t state_q;
	logic   done_q;

	// Busy only while the apply step is pending.
	assign busy = (state_q == S_APPLY);
	assign done = done_q;

	// An item is taken whenever start arrives outside the apply step.
	assign cmd.capture = start && (state_q == S_IDLE);
	assign cmd.apply   = (state_q == S_APPLY);

	// State and registered result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					done_q <= 1'b0;
					if (start) begin
						state_q <= S_APPLY;
					end
				end
				S_APPLY: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					done_q  <= 1'b0;
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== sv/sidt_datapath.sv =====
// Datapath for the sorted ID table: a row of ID cells, each with its own
// comparator and neighbor shift, the fill count and the result registers.
// Depends on sidt_pkg.
module sidt_datapath
	import sidt_pkg::*;
#(
	parameter int CAPACITY = 256,
	parameter int ID_BITS  = 16,
	parameter int CNT_W    = 9
) (
	input  logic               clk,
	input  logic               arst_n,
	input  sidt_cmd_t          cmd,
	input  logic [1:0]         opcode,
	input  logic [ID_BITS-1:0] user_id,
	output logic               found,
	output logic [1:0]         status,
	output logic [CNT_W-1:0]   entry_count
);

	// Cell contents; entries at or beyond the count are never used.
	logic [ID_BITS-1:0]  cell_q [CAPACITY];
	logic [CNT_W-1:0]    count_q;

	// Item and compare flags registered at capture.
	op_t                 op_s1;
	logic [ID_BITS-1:0]  key_s1;
	logic [CAPACITY-1:0] gt_s1;   // valid entry greater than the key
	logic [CAPACITY-1:0] ge_s1;   // valid entry greater than or equal to the key

	logic                found_q;
	status_t             status_q;

	logic [CAPACITY-1:0] gt_d;
	logic [CAPACITY-1:0] ge_d;
	logic                hit;
	logic                full;
	logic                do_insert;
	logic                do_delete;

	// Per-cell comparison against the incoming ID.
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			gt_d[i] = (CNT_W'(i) < count_q) && (cell_q[i] > user_id);
			ge_d[i] = (CNT_W'(i) < count_q) && (cell_q[i] >= user_id);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_s1  <= op_t'(opcode);
			key_s1 <= user_id;
			gt_s1  <= gt_d;
			ge_s1  <= ge_d;
		end
	end

	// Equal entries are those at or above the key but not above it.
	assign hit       = |(ge_s1 & ~gt_s1);
	assign full      = (count_q == CNT_W'(CAPACITY));
	assign do_insert = cmd.apply && (op_s1 == OP_INSERT) && !full;
	assign do_delete = cmd.apply && (op_s1 == OP_DELETE) && hit;

	// Cell row: insert opens a gap after the last entry not above the key,
	// delete pulls every entry from the first match upward down by one.
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic from_left;
		logic take_key;
		logic from_right;

		if (g == 0) begin : g_first
			assign from_left = 1'b0;
			assign take_key  = gt_s1[g] || (count_q == CNT_W'(g));
		end else begin : g_rest
			assign from_left = gt_s1[g-1];
			assign take_key  = (gt_s1[g] || (count_q == CNT_W'(g))) && !gt_s1[g-1];
		end

		if (g == CAPACITY - 1) begin : g_last
			assign from_right = 1'b0;
		end else begin : g_inner
			assign from_right = ge_s1[g];
		end

		always_ff @(posedge clk) begin
			if (do_insert) begin
				if (from_left) begin
					cell_q[g] <= cell_q[(g == 0) ? 0 : g - 1];
				end else if (take_key) begin
					cell_q[g] <= key_s1;
				end
			end else if (do_delete && from_right) begin
				cell_q[g] <= cell_q[(g == CAPACITY - 1) ? g : g + 1];
			end
		end
	end

	// Fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (do_insert) begin
			count_q <= count_q + CNT_W'(1);
		end else if (do_delete) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	// Result fields, formed in the apply step.
	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			unique case (op_s1)
				OP_INSERT: begin
					found_q  <= 1'b0;
					status_q <= full ? ST_FULL : ST_OK;
				end
				OP_DELETE, OP_LOOKUP: begin
					found_q  <= hit;
					status_q <= hit ? ST_OK : ST_NOT_FOUND;
				end
				default: begin
					found_q  <= 1'b0;
					status_q <= ST_OK;
				end
			endcase
		end
	end

	assign found       = found_q;
	assign status      = status_q;
	assign entry_count = count_q;

endmodule

// ===== sv/sorted_id_table_top.sv =====
// Sorted ID table: insert, delete and look up IDs in an ascending table.
// done is registered from the apply state that follows the accepting edge.
// A new item is taken only while idle: the compare step is followed by
// the shift step of the cell row, and busy is high for the shift step.
// Reset clears the count and the control; cell contents are left as they are.
// Results are shown for one cycle on done; the receiver cannot stall them.
module sorted_id_table_top
	import sidt_pkg::*;
#(
	parameter int CAPACITY = 256,
	parameter int ID_BITS  = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [1:0]                         opcode,
	input  logic [ID_BITS-1:0]                 user_id,
	output logic                               done,
	output logic                               found,
	output logic [1:0]                         status,
	output logic [$clog2(CAPACITY+1)-1:0]      entry_count
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	sidt_cmd_t cmd;

	// Sequencer.
	sidt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	// Cell row and result registers.
	sidt_datapath #(
		.CAPACITY (CAPACITY),
		.ID_BITS  (ID_BITS),
		.CNT_W    (CNT_W)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.opcode      (opcode),
		.user_id     (user_id),
		.found       (found),
		.status      (status),
		.entry_count (entry_count)
	);

endmodule
